@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros shared by the rtl files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("implication check failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// condition must never hold
`define ASSERT_NEVER(label, ck, rn, expr) \
    label: assert property (@(posedge ck) disable iff (!rn) !(expr)) \
        else $error("forbidden condition seen");

`endif

@@ hdl/bce_pkg.sv @@
// ----------------------------------------------------------------------------
// bce_pkg
// shared widths, the charge curve and the queue word of the charge estimator
// ----------------------------------------------------------------------------
package bce_pkg;

    localparam int SAMPLE_BITS  = 10;
    localparam int RAW_W        = SAMPLE_BITS + 1;
    localparam int MV_W         = 13;
    localparam int PCT_W        = 7;
    localparam int TABLE_POINTS = 13;
    localparam int IDX_W        = $clog2(TABLE_POINTS);

    // 600 mV reference, x4 input gain, x2 divider
    localparam int MV_SCALE     = 600 * 4 * 2;
    localparam int FULL_SCALE   = (1 << SAMPLE_BITS) - 1;
    localparam int PROD_W       = SAMPLE_BITS + $clog2(MV_SCALE + 1);

    localparam int SEG_W        = 8;   // widest segment is 135 mV
    localparam int SPAN_W       = 4;   // widest segment spans 10 percent
    localparam int NUM_W        = SEG_W + SPAN_W;
    localparam int QUO_W        = 4;   // quotient never exceeds the span

    localparam int QDEPTH       = 8;
    localparam int QPTR_W       = $clog2(QDEPTH);
    localparam int QCNT_W       = $clog2(QDEPTH + 1);

    localparam logic [PCT_W-1:0] PCT_MAX = PCT_W'(100);

    localparam logic [MV_W-1:0] CURVE_MV [TABLE_POINTS] = '{
        13'd3300, 13'd3414, 13'd3503, 13'd3535, 13'd3560, 13'd3602, 13'd3642,
        13'd3698, 13'd3783, 13'd3871, 13'd3963, 13'd4065, 13'd4200
    };

    localparam logic [PCT_W-1:0] CURVE_PCT [TABLE_POINTS] = '{
        7'd0, 7'd5, 7'd15, 7'd20, 7'd25, 7'd35, 7'd45,
        7'd55, 7'd65, 7'd75, 7'd85, 7'd95, 7'd100
    };

    typedef enum logic [1:0] {
        CLS_BELOW  = 2'd0,
        CLS_INSIDE = 2'd1,
        CLS_ABOVE  = 2'd2
    } seg_class_t;

    typedef struct packed {
        logic [MV_W-1:0]  mv;
        logic             neg;
        seg_class_t       cls;
        logic [IDX_W-1:0] idx;   // upper point of the segment
    } q_entry_t;

endpackage

@@ hdl/bce_front.sv @@
// ----------------------------------------------------------------------------
// bce_front
// accepts samples, scales them to millivolts and classifies the curve segment
// ----------------------------------------------------------------------------
module bce_front
    import bce_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [RAW_W-1:0] raw_sample,
    input  logic [QCNT_W-1:0]       q_count,
    output logic                    push,
    output q_entry_t                push_word
);

    logic              f1_valid_reg, f2_valid_reg, f3_valid_reg;
    logic [PROD_W-1:0] f1_prod_reg, f2_prod_reg;
    logic              f1_neg_reg, f2_neg_reg, f3_neg_reg;
    logic [MV_W-1:0]   f2_est_reg, f3_mv_reg;

    logic              accept;
    logic [PROD_W-1:0] prod_next;
    logic [PROD_W:0]   est_sum;
    logic [MV_W-1:0]   est_next;
    logic [PROD_W-1:0] rem;
    logic [MV_W-1:0]   mv_next;
    logic [1:0]        inflight;
    logic [QCNT_W:0]   credit_used;
    seg_class_t        cls;
    logic [IDX_W-1:0]  idx;

    // each word in flight may still need a queue slot
    assign inflight    = 2'(f1_valid_reg) + 2'(f2_valid_reg) + 2'(f3_valid_reg);
    assign credit_used = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(inflight);
    assign busy        = credit_used >= (QCNT_W+1)'(QDEPTH);
    assign accept      = start && !busy;

    assign prod_next = raw_sample[RAW_W-1] ? '0 :
                       PROD_W'(raw_sample[SAMPLE_BITS-1:0]) * PROD_W'(MV_SCALE);

    // x / (2^n - 1) estimated from below by x * (1 + 2^-n + 2^-2n) / 2^n
    assign est_sum  = (PROD_W+1)'(f1_prod_reg)
                    + (PROD_W+1)'(f1_prod_reg >> SAMPLE_BITS)
                    + (PROD_W+1)'(f1_prod_reg >> (2 * SAMPLE_BITS));
    assign est_next = MV_W'(est_sum >> SAMPLE_BITS);

    // estimate is at most one low
    assign rem     = f2_prod_reg - (PROD_W'(f2_est_reg) << SAMPLE_BITS)
                   + PROD_W'(f2_est_reg);
    assign mv_next = f2_est_reg + MV_W'(rem >= PROD_W'(FULL_SCALE));

    always_comb
    begin
        idx = IDX_W'(TABLE_POINTS - 1);
        for (int i = TABLE_POINTS - 1; i >= 1; i--)
        begin
            if (f3_mv_reg <= CURVE_MV[i])
            begin
                idx = IDX_W'(i);
            end
        end
        if (f3_mv_reg < CURVE_MV[0])
        begin
            cls = CLS_BELOW;
        end
        else if (f3_mv_reg > CURVE_MV[TABLE_POINTS-1])
        begin
            cls = CLS_ABOVE;
        end
        else
        begin
            cls = CLS_INSIDE;
        end
    end

    assign push          = f3_valid_reg;
    assign push_word.mv  = f3_mv_reg;
    assign push_word.neg = f3_neg_reg;
    assign push_word.cls = cls;
    assign push_word.idx = idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
        end
        else
        begin
            f1_valid_reg <= accept;
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        f1_prod_reg <= prod_next;
        f1_neg_reg  <= raw_sample[RAW_W-1];
        f2_prod_reg <= f1_prod_reg;
        f2_est_reg  <= est_next;
        f2_neg_reg  <= f1_neg_reg;
        f3_mv_reg   <= mv_next;
        f3_neg_reg  <= f2_neg_reg;
    end

endmodule

@@ hdl/bce_queue.sv @@
// ----------------------------------------------------------------------------
// bce_queue
// small register queue between the classifying front and the arithmetic back
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bce_queue
    import bce_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  q_entry_t          push_word,
    output logic              pop,
    output q_entry_t          pop_word,
    output logic [QCNT_W-1:0] count
);

    q_entry_t            mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg, count_next;

    // the back never stalls, so any stored word leaves at once
    assign pop      = count_reg != '0;
    assign pop_word = mem_reg[rd_ptr_reg];
    assign count    = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

    `ASSERT_NEVER(q_no_overflow, clk, rst_n, push && !pop && count_reg == QCNT_W'(QDEPTH))
    `ASSERT_IMPLIES(q_empty_ptrs, clk, rst_n, count_reg == '0, wr_ptr_reg == rd_ptr_reg)

endmodule

@@ hdl/bce_back.sv @@
// ----------------------------------------------------------------------------
// bce_back
// interpolates inside the segment with a pipelined restoring divider; outside the curve it gives 0 or 100 percent
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bce_back
    import bce_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop,
    input  q_entry_t         pop_word,
    output logic             done,
    output logic [MV_W-1:0]  battery_mv,
    output logic [PCT_W-1:0] charge_percent,
    output logic             sample_negative
);

    typedef struct packed {
        logic [MV_W-1:0]  mv;
        logic             neg;
        seg_class_t       cls;
        logic [PCT_W-1:0] lo_pct;
        logic [SEG_W-1:0] width;
    } carry_t;

    logic              b1_valid_reg;
    carry_t            b1_car_reg;
    logic [SEG_W-1:0]  b1_diff_reg;
    logic [SPAN_W-1:0] b1_span_reg;

    logic              dv_valid_reg [QUO_W+1];
    carry_t            dv_car_reg   [QUO_W+1];
    logic [NUM_W-1:0]  dv_rem_reg   [QUO_W+1];
    logic [QUO_W-1:0]  dv_quo_reg   [QUO_W+1];
    logic [NUM_W-1:0]  dv_rem_next  [QUO_W];
    logic [QUO_W-1:0]  dv_quo_next  [QUO_W];

    logic              out_valid_reg;
    logic [MV_W-1:0]   out_mv_reg;
    logic [PCT_W-1:0]  out_pct_reg, pct_next;
    logic              out_neg_reg;

    logic [MV_W-1:0]   lo_mv;
    logic [IDX_W-1:0]  lo_idx;
    carry_t            car_next;
    logic [NUM_W-1:0]  num_next;

    assign lo_idx          = pop_word.idx - 1'b1;
    assign lo_mv           = CURVE_MV[lo_idx];
    assign car_next.mv     = pop_word.mv;
    assign car_next.neg    = pop_word.neg;
    assign car_next.cls    = pop_word.cls;
    assign car_next.lo_pct = CURVE_PCT[lo_idx];
    assign car_next.width  = SEG_W'(CURVE_MV[pop_word.idx] - lo_mv);

    // rounded numerator: offset times span plus half the width
    assign num_next = NUM_W'(b1_diff_reg) * NUM_W'(b1_span_reg)
                    + NUM_W'(b1_car_reg.width >> 1);

    always_comb
    begin
        for (int s = 0; s < QUO_W; s++)
        begin
            dv_rem_next[s] = dv_rem_reg[s];
            dv_quo_next[s] = dv_quo_reg[s];
            if (dv_rem_reg[s] >= (NUM_W'(dv_car_reg[s].width) << (QUO_W - 1 - s)))
            begin
                dv_rem_next[s] = dv_rem_reg[s]
                               - (NUM_W'(dv_car_reg[s].width) << (QUO_W - 1 - s));
                dv_quo_next[s] = dv_quo_reg[s] | (QUO_W'(1) << (QUO_W - 1 - s));
            end
        end
    end

    always_comb
    begin
        case (dv_car_reg[QUO_W].cls)
            CLS_INSIDE: pct_next = dv_car_reg[QUO_W].lo_pct + PCT_W'(dv_quo_reg[QUO_W]);
            CLS_ABOVE:  pct_next = PCT_MAX;
            default:    pct_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int s = 0; s <= QUO_W; s++)
            begin
                dv_valid_reg[s] <= 1'b0;
            end
        end
        else
        begin
            b1_valid_reg    <= pop;
            dv_valid_reg[0] <= b1_valid_reg;
            for (int s = 0; s < QUO_W; s++)
            begin
                dv_valid_reg[s+1] <= dv_valid_reg[s];
            end
            out_valid_reg <= dv_valid_reg[QUO_W];
        end
    end

    always_ff @(posedge clk)
    begin
        b1_car_reg    <= car_next;
        b1_diff_reg   <= SEG_W'(pop_word.mv - lo_mv);
        b1_span_reg   <= SPAN_W'(CURVE_PCT[pop_word.idx] - CURVE_PCT[lo_idx]);
        dv_car_reg[0] <= b1_car_reg;
        dv_rem_reg[0] <= num_next;
        dv_quo_reg[0] <= '0;
        for (int s = 0; s < QUO_W; s++)
        begin
            dv_car_reg[s+1] <= dv_car_reg[s];
            dv_rem_reg[s+1] <= dv_rem_next[s];
            dv_quo_reg[s+1] <= dv_quo_next[s];
        end
        out_mv_reg  <= dv_car_reg[QUO_W].mv;
        out_neg_reg <= dv_car_reg[QUO_W].neg;
        out_pct_reg <= pct_next;
    end

    assign done            = out_valid_reg;
    assign battery_mv      = out_mv_reg;
    assign charge_percent  = out_pct_reg;
    assign sample_negative = out_neg_reg;

    `ASSERT_IMPLIES(pct_in_range, clk, rst_n, done, charge_percent <= PCT_MAX)
    `ASSERT_IMPLIES(neg_reads_zero, clk, rst_n, done && sample_negative, battery_mv == '0 && charge_percent == '0)

endmodule

@@ hdl/battery_charge_estimator.sv @@
// ----------------------------------------------------------------------------
// battery_charge_estimator
// converter sample to battery millivolts and interpolated state of charge
// ----------------------------------------------------------------------------
//  channel   handshake        payload
//  input     start / busy     raw_sample
//  result    done (strobe)    battery_mv, charge_percent, sample_negative
//
//  one sample a cycle while busy is low; from the accepting edge to done there are
//  eleven register stages in all: three scaling stages, queue slot, segment
//  lookup, numerator, four divider steps and the output register
//  busy only rises if the queue credit runs out, which the never-stalling
//  back end keeps from happening; reset clears all valid state at once
// ----------------------------------------------------------------------------
module battery_charge_estimator
    import bce_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [RAW_W-1:0] raw_sample,
    output logic                    done,
    output logic [MV_W-1:0]         battery_mv,
    output logic [PCT_W-1:0]        charge_percent,
    output logic                    sample_negative
);

    logic              push, pop;
    q_entry_t          push_word, pop_word;
    logic [QCNT_W-1:0] q_count;

    bce_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .raw_sample (raw_sample),
        .q_count    (q_count),
        .push       (push),
        .push_word  (push_word)
    );

    bce_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .pop_word  (pop_word),
        .count     (q_count)
    );

    bce_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .pop             (pop),
        .pop_word        (pop_word),
        .done            (done),
        .battery_mv      (battery_mv),
        .charge_percent  (charge_percent),
        .sample_negative (sample_negative)
    );

endmodule
